// ----- hdl/cpm_pkg.sv -----
// shared types and constants for the closest pair (manhattan) unit
`default_nettype none

package cpm_pkg;

    // fixed field widths
    localparam int COORD_IN_W = 16;
    localparam int DIST_W     = 18;
    localparam int IDX_OUT_W  = 8;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // defaults for the top level parameters
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_COORD_BITS = 16;

    localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

    // search sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_RD_I,
        ST_LAT_I,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/cpm_point_store.sv -----
// point store: one write port, one read port with registered read data
`default_nettype none

module cpm_point_store #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/cpm_dist_unit.sv -----
// two-stage manhattan distance unit with saturation to the result width
`default_nettype none

module cpm_dist_unit #(
    parameter int COORD_BITS = 16,
    parameter int TAG_W      = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [TAG_W-1:0]      i_tag,
    input  wire logic [COORD_BITS-1:0] i_ax,
    input  wire logic [COORD_BITS-1:0] i_ay,
    input  wire logic [COORD_BITS-1:0] i_bx,
    input  wire logic [COORD_BITS-1:0] i_by,
    output logic                       o_valid,
    output logic [TAG_W-1:0]           o_tag,
    output logic [cpm_pkg::DIST_W-1:0] o_dist,
    output logic                       o_busy
);

    import cpm_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int SUM_W = CW + 1;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    logic          r_v1;
    logic [TAG_W-1:0] r_tag1;
    logic [CW-1:0] r_adx;
    logic [CW-1:0] r_ady;
    logic          r_v2;
    logic [TAG_W-1:0] r_tag2;
    logic [DIST_W-1:0] r_dist;

    logic [CW:0]    dx;
    logic [CW:0]    dy;
    logic [CW:0]    mdx;
    logic [CW:0]    mdy;
    logic [SUM_W-1:0] sum;
    logic [EXT_W-1:0] sum_ext;
    logic [DIST_W-1:0] sat;

    // stage 1: signed differences and their magnitudes
    always_comb begin
        dx  = {i_ax[CW-1], i_ax} - {i_bx[CW-1], i_bx};
        dy  = {i_ay[CW-1], i_ay} - {i_by[CW-1], i_by};
        mdx = dx[CW] ? (~dx + 1'b1) : dx;
        mdy = dy[CW] ? (~dy + 1'b1) : dy;
    end

    // stage 2: sum and clamp to the distance width
    always_comb begin
        sum     = {1'b0, r_adx} + {1'b0, r_ady};
        sum_ext = EXT_W'(sum);
        sat     = (sum_ext > EXT_W'(DIST_ALL_ONES)) ? DIST_ALL_ONES : sum_ext[DIST_W-1:0];
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_tag1 <= i_tag;
        r_adx  <= mdx[CW-1:0];
        r_ady  <= mdy[CW-1:0];
        r_tag2 <= r_tag1;
        r_dist <= sat;
    end

    assign o_valid = r_v2;
    assign o_tag   = r_tag2;
    assign o_dist  = r_dist;
    assign o_busy  = r_v1 | r_v2;

endmodule

`default_nettype wire

// ----- hdl/closest_pair_manhattan_unit.sv -----
// closest pair (manhattan) unit: point loading, pair search sequencer, result register
// loading: points load at one item per cycle; after the last point the search walks all
// pairs through one distance unit and the single store read port for n stored points
// (it goes straight to the result when fewer than two points are stored)
// throughput: one set at a time; the input is not ready from the last point until the
// result item is taken; reset clears control state only, no clearing pass on the store
`default_nettype none

module closest_pair_manhattan_unit #(
    parameter int MAX_POINTS = cpm_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = cpm_pkg::DEF_COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [15:0] px, [31:16] py
    input  wire logic [cpm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [17:0] best_distance, [25:18] first_index, [33:26] second_index, [39:34] zero
    output logic [cpm_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] found
    output logic [0:0]                         o_m_axis_tuser
);

    import cpm_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int TAG_W  = 2 * ADDR_W;
    localparam int CIN_W  = (COORD_IN_W > CW) ? COORD_IN_W : CW;
    localparam int IEXT_W = ADDR_W + IDX_OUT_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [CW-1:0]     r_xi, n_xi;
    logic [CW-1:0]     r_yi, n_yi;
    logic              r_rdv;
    logic              n_issue;
    logic [TAG_W-1:0]  r_tag_rd;
    logic [DIST_W-1:0] r_best, n_best;
    logic [ADDR_W-1:0] r_bi, n_bi;
    logic [ADDR_W-1:0] r_bj, n_bj;
    logic              r_any, n_any;

    // store ports
    logic              st_we;
    logic [ADDR_W-1:0] st_raddr;
    logic [2*CW-1:0]   st_wdata;
    logic [2*CW-1:0]   st_rdata;

    // distance unit outputs
    logic              du_valid;
    logic [TAG_W-1:0]  du_tag;
    logic [DIST_W-1:0] du_dist;
    logic              du_busy;

    logic              in_acc;
    logic [CIN_W-1:0]  px_ext;
    logic [CIN_W-1:0]  py_ext;
    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W-1:0]  prev_idx;
    logic [IEXT_W-1:0] bi_ext;
    logic [IEXT_W-1:0] bj_ext;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign px_ext   = CIN_W'(i_s_axis_tdata[COORD_IN_W-1:0]);
    assign py_ext   = CIN_W'(i_s_axis_tdata[2*COORD_IN_W-1:COORD_IN_W]);
    assign st_wdata = {py_ext[CW-1:0], px_ext[CW-1:0]};
    assign st_we    = in_acc && (r_count < CNT_W'(MAX_POINTS));
    assign last_idx = r_count - 1'b1;
    assign prev_idx = r_count - CNT_W'(2);

    cpm_point_store #(
        .DEPTH  (MAX_POINTS),
        .WIDTH  (2 * CW),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    cpm_dist_unit #(
        .COORD_BITS (CW),
        .TAG_W      (TAG_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rdv),
        .i_tag   (r_tag_rd),
        .i_ax    (r_xi),
        .i_ay    (r_yi),
        .i_bx    (st_rdata[CW-1:0]),
        .i_by    (st_rdata[2*CW-1:CW]),
        .o_valid (du_valid),
        .o_tag   (du_tag),
        .o_dist  (du_dist),
        .o_busy  (du_busy)
    );

    // sequencer: next state, pair indices and running best
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_xi     = r_xi;
        n_yi     = r_yi;
        n_issue  = 1'b0;
        n_best   = r_best;
        n_bi     = r_bi;
        n_bj     = r_bj;
        n_any    = r_any;
        st_raddr = r_j;

        // fold finished distances into the running best, pairs arrive in order
        if (du_valid && (!r_any || du_dist < r_best)) begin
            n_best = du_dist;
            n_bi   = du_tag[TAG_W-1:ADDR_W];
            n_bj   = du_tag[ADDR_W-1:0];
            n_any  = 1'b1;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (st_we) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_best = DIST_ALL_ONES;
                n_bi   = '0;
                n_bj   = '0;
                n_any  = 1'b0;
                n_i    = '0;
                if (r_count < CNT_W'(2)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                st_raddr = r_i;
                n_state  = ST_LAT_I;
            end
            ST_LAT_I: begin
                n_xi    = st_rdata[CW-1:0];
                n_yi    = st_rdata[2*CW-1:CW];
                n_j     = r_i + 1'b1;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                st_raddr = r_j;
                n_issue  = 1'b1;
                if (r_j == last_idx[ADDR_W-1:0]) begin
                    if (r_i == prev_idx[ADDR_W-1:0]) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_RD_I;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rdv && !du_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_count = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_rdv   <= 1'b0;
            r_best  <= DIST_ALL_ONES;
            r_bi    <= '0;
            r_bj    <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rdv   <= n_issue;
            r_best  <= n_best;
            r_bi    <= n_bi;
            r_bj    <= n_bj;
            r_any   <= n_any;
        end
    end

    // pair indices and the latched first point
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_xi     <= n_xi;
        r_yi     <= n_yi;
        r_tag_rd <= {r_i, r_j};
    end

    // result item
    assign bi_ext = IEXT_W'(r_bi);
    assign bj_ext = IEXT_W'(r_bj);

    assign o_s_axis_tready   = (r_state == ST_LOAD);
    assign o_m_axis_tvalid   = (r_state == ST_OUT);
    assign o_m_axis_tdata    = M_TDATA_W'({bj_ext[IDX_OUT_W-1:0], bi_ext[IDX_OUT_W-1:0], r_best});
    assign o_m_axis_tuser[0] = r_any;

    // input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    // a found pair is ordered first below second
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_any) |-> (r_bi < r_bj))
        else $error("pair indices out of order");

    // no pair means the distance is all ones
    a_no_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (r_best == DIST_ALL_ONES))
        else $error("distance set without a pair");

    // the result is shown only once the distance pipeline is empty
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!r_rdv && !du_busy))
        else $error("result shown with distances in flight");

endmodule

`default_nettype wire
